// File: sv/price_level_depth_merger_macros.svh
// ---------------------------------------------------------------------------
// price_level_depth_merger_macros.svh
// Assertion shorthands shared by the depth merger RTL.
// ---------------------------------------------------------------------------
`ifndef PRICE_LEVEL_DEPTH_MERGER_MACROS_SVH
`define PRICE_LEVEL_DEPTH_MERGER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PLD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pld_pkg.sv
// ---------------------------------------------------------------------------
// pld_pkg
// Types and codes shared by the price level depth merger.
// ---------------------------------------------------------------------------
`default_nettype none

package pld_pkg;

    localparam int PRICE_W  = 32;
    localparam int QTY_W    = 64;
    localparam int ORD_W    = 32;
    localparam int LEVELS_W = 5;
    localparam int LIMIT_W  = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // register index, taken from paddr[2]
    localparam logic REG_LEVEL_LIMIT = 1'b0;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_MERGE  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_LEVEL   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] STAT_NONE    = 2'd0;
    localparam logic [1:0] STAT_OVF     = 2'd1;
    localparam logic [1:0] STAT_CROSSED = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACT,
        ST_READ
    } t_state;

    typedef struct packed {
        logic signed [PRICE_W-1:0] price;
        logic [QTY_W-1:0]          quantity;
        logic [ORD_W-1:0]          orders;
    } t_entry;

    typedef struct packed {
        logic [1:0]                kind;
        logic [1:0]                status;
        logic                      level_side;
        logic signed [PRICE_W-1:0] level_price;
        logic [QTY_W-1:0]          level_quantity;
        logic [ORD_W-1:0]          level_orders;
        logic [LEVELS_W-1:0]       bid_levels;
        logic [LEVELS_W-1:0]       ask_levels;
        logic                      crossed;
        logic                      last;
    } t_res;

    typedef struct packed {
        logic load;
        logic commit;
        logic is_ask;
    } t_side_ctl;

    typedef struct packed {
        logic match;
        logic ovf;
        logic drop;
    } t_side_stat;

endpackage

`default_nettype wire

// File: sv/pld_if.sv
// ---------------------------------------------------------------------------
// pld_in_if / pld_out_if
// Valid/ready channels for incoming levels and outgoing result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface pld_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic               side;
    logic signed [31:0] price;
    logic [63:0]        quantity;
    logic [31:0]        orders;

    modport source (output valid, op, side, price, quantity, orders, input ready);
    modport sink   (input valid, op, side, price, quantity, orders, output ready);
endinterface

interface pld_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [1:0]         status;
    logic               level_side;
    logic signed [31:0] level_price;
    logic [63:0]        level_quantity;
    logic [31:0]        level_orders;
    logic [4:0]         bid_levels;
    logic [4:0]         ask_levels;
    logic               crossed;
    logic               last;

    modport source (output valid, kind, status, level_side, level_price, level_quantity,
                    level_orders, bid_levels, ask_levels, crossed, last, input ready);
    modport sink   (input valid, kind, status, level_side, level_price, level_quantity,
                    level_orders, bid_levels, ask_levels, crossed, last, output ready);
endinterface

`default_nettype wire

// File: sv/price_level_depth_merger.sv
// ---------------------------------------------------------------------------
// price_level_depth_merger
// Consolidated bid/ask depth built from price levels merged one at a time.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one command word: clear, merge a level, or finish. o_out
//   returns result words; the last word of each command has last set.
//   Clear and merge return one status word. Finish returns every bid level
//   best first, then every ask level, then a summary word.
//   level_limit is written over APB at address 0 while the block is idle.
// Sequencing:
//   A merge compares and adds in the cell row in the accept cycle; the
//   ST_ACT state then commits the aggregate, insert or shift and posts
//   the status word once o_out can take it; clear posts its word the same
//   way. Finish goes through the accept cycle, a setup state, one word per
//   cycle from the cell read mux while o_out is not stalled, a turn from the
//   bid row to the ask row, and the summary. One command is in flight at a
//   time; the next is taken once the last word of the current one has been
//   loaded into the output register.
// Reset clears both counts, the sticky error and the output valid, and
//   sets level_limit to 16; entry contents are not cleared.
// A stalled o_out holds its word; the command sequencer waits behind it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "price_level_depth_merger_macros.svh"

module price_level_depth_merger #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pld_in_if.sink                        i_in,
    pld_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pld_pkg::PADDR_W-1:0]   paddr,
    input  logic [pld_pkg::PDATA_W-1:0]   pwdata,
    output logic [pld_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import pld_pkg::*;

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    t_state          r_state, n_state;
    t_entry          r_item;
    logic [1:0]      r_op;
    logic            r_side;
    logic [LIMIT_W-1:0] r_limit;
    logic [CW-1:0]   r_bid_cnt, n_bid_cnt;
    logic [CW-1:0]   r_ask_cnt, n_ask_cnt;
    logic            r_sticky, n_sticky;
    logic            r_rd_side, n_rd_side;
    logic [CW-1:0]   r_rd_idx, n_rd_idx;
    logic            r_out_valid, n_out_valid;
    t_res            r_res, n_res;

    t_entry          w_item;
    t_entry          w_bid_rd, w_ask_rd;
    t_side_stat      w_bid_stat, w_ask_stat, w_sel_stat;
    t_side_ctl       w_bid_ctl, w_ask_ctl;
    logic signed [PRICE_W-1:0] w_bid_head, w_ask_head;
    logic [CW-1:0]   w_cap;
    logic [CW-1:0]   w_sel_cnt;
    logic            w_acc;
    logic            w_slot;
    logic            w_commit;
    logic            w_crossed;
    logic            w_cfg_wr;

    // ---------------- configuration ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign prdata   = (paddr[PADDR_W-1] == REG_LEVEL_LIMIT) ? PDATA_W'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (w_cfg_wr && paddr[PADDR_W-1] == REG_LEVEL_LIMIT) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // zero acts as one, anything above the row length as the row length
    always_comb begin
        if (r_limit == '0) begin
            w_cap = CW'(1);
        end else if (r_limit > LIMIT_W'(MAX_DEPTH)) begin
            w_cap = CW'(MAX_DEPTH);
        end else begin
            w_cap = r_limit[CW-1:0];
        end
    end

    // ---------------- cell rows ----------------
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_acc      = i_in.valid & i_in.ready;
    assign w_slot     = ~r_out_valid | o_out.ready;

    always_comb begin
        if (r_state == ST_IDLE) begin
            w_item.price    = i_in.price;
            w_item.quantity = i_in.quantity;
            w_item.orders   = i_in.orders;
        end else begin
            w_item = r_item;
        end
    end

    assign w_bid_ctl.load   = w_acc;
    assign w_bid_ctl.commit = w_commit & ~r_side;
    assign w_bid_ctl.is_ask = 1'b0;
    assign w_ask_ctl.load   = w_acc;
    assign w_ask_ctl.commit = w_commit & r_side;
    assign w_ask_ctl.is_ask = 1'b1;

    pld_side #(.MAX_DEPTH(MAX_DEPTH)) u_bid (
        .i_clk        (i_clk),
        .i_ctl        (w_bid_ctl),
        .i_item       (w_item),
        .i_count      (r_bid_cnt),
        .i_cap        (w_cap),
        .i_rd_idx     (r_rd_idx[IW-1:0]),
        .o_stat       (w_bid_stat),
        .o_rd         (w_bid_rd),
        .o_head_price (w_bid_head)
    );

    pld_side #(.MAX_DEPTH(MAX_DEPTH)) u_ask (
        .i_clk        (i_clk),
        .i_ctl        (w_ask_ctl),
        .i_item       (w_item),
        .i_count      (r_ask_cnt),
        .i_cap        (w_cap),
        .i_rd_idx     (r_rd_idx[IW-1:0]),
        .o_stat       (w_ask_stat),
        .o_rd         (w_ask_rd),
        .o_head_price (w_ask_head)
    );

    assign w_sel_stat = r_side ? w_ask_stat : w_bid_stat;
    assign w_sel_cnt  = r_side ? r_ask_cnt : r_bid_cnt;
    assign w_crossed  = ~r_sticky && (r_bid_cnt != '0) && (r_ask_cnt != '0) &&
                        (w_bid_head > w_ask_head);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bid_cnt   <= '0;
            r_ask_cnt   <= '0;
            r_sticky    <= 1'b0;
            r_rd_side   <= 1'b0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bid_cnt   <= n_bid_cnt;
            r_ask_cnt   <= n_ask_cnt;
            r_sticky    <= n_sticky;
            r_rd_side   <= n_rd_side;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_acc) begin
            r_op   <= i_in.op;
            r_side <= i_in.side;
            r_item <= w_item;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bid_cnt   = r_bid_cnt;
        n_ask_cnt   = r_ask_cnt;
        n_sticky    = r_sticky;
        n_rd_side   = r_rd_side;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_res       = r_res;
        w_commit    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = ST_ACT;
                end
            end
            ST_ACT: begin
                case (r_op)
                    OP_CLEAR: begin
                        if (w_slot) begin
                            n_bid_cnt   = '0;
                            n_ask_cnt   = '0;
                            n_sticky    = 1'b0;
                            n_res       = '0;
                            n_res.kind  = KIND_STATUS;
                            n_res.last  = 1'b1;
                            n_out_valid = 1'b1;
                            n_state     = ST_IDLE;
                        end
                    end
                    OP_MERGE: begin
                        if (w_slot) begin
                            n_res       = '0;
                            n_res.kind  = KIND_STATUS;
                            n_res.last  = 1'b1;
                            n_out_valid = 1'b1;
                            n_state     = ST_IDLE;
                            if (r_sticky) begin
                                n_res.status = STAT_OVF;
                            end else begin
                                w_commit = 1'b1;
                                if (w_sel_stat.ovf) begin
                                    n_sticky     = 1'b1;
                                    n_res.status = STAT_OVF;
                                end else begin
                                    n_res.status = STAT_NONE;
                                    // new level kept: the row grows unless already at the limit
                                    if (!w_sel_stat.match && !w_sel_stat.drop &&
                                        w_sel_cnt < w_cap) begin
                                        if (r_side) begin
                                            n_ask_cnt = r_ask_cnt + CW'(1);
                                        end else begin
                                            n_bid_cnt = r_bid_cnt + CW'(1);
                                        end
                                    end
                                end
                            end
                        end
                    end
                    OP_FINISH: begin
                        n_rd_side = 1'b0;
                        n_rd_idx  = '0;
                        n_state   = ST_READ;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_READ: begin
                if (w_slot) begin
                    if (!r_rd_side) begin
                        if (r_rd_idx < r_bid_cnt) begin
                            n_res                = '0;
                            n_res.kind           = KIND_LEVEL;
                            n_res.level_side     = 1'b0;
                            n_res.level_price    = w_bid_rd.price;
                            n_res.level_quantity = w_bid_rd.quantity;
                            n_res.level_orders   = w_bid_rd.orders;
                            n_out_valid          = 1'b1;
                            n_rd_idx             = r_rd_idx + CW'(1);
                        end else begin
                            n_rd_side = 1'b1;
                            n_rd_idx  = '0;
                        end
                    end else begin
                        if (r_rd_idx < r_ask_cnt) begin
                            n_res                = '0;
                            n_res.kind           = KIND_LEVEL;
                            n_res.level_side     = 1'b1;
                            n_res.level_price    = w_ask_rd.price;
                            n_res.level_quantity = w_ask_rd.quantity;
                            n_res.level_orders   = w_ask_rd.orders;
                            n_out_valid          = 1'b1;
                            n_rd_idx             = r_rd_idx + CW'(1);
                        end else begin
                            n_res            = '0;
                            n_res.kind       = KIND_SUMMARY;
                            n_res.status     = r_sticky ? STAT_OVF
                                             : (w_crossed ? STAT_CROSSED : STAT_NONE);
                            n_res.bid_levels = LEVELS_W'(r_bid_cnt);
                            n_res.ask_levels = LEVELS_W'(r_ask_cnt);
                            n_res.crossed    = w_crossed;
                            n_res.last       = 1'b1;
                            n_out_valid      = 1'b1;
                            n_state          = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------- result port ----------------
    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_res.kind;
    assign o_out.status         = r_res.status;
    assign o_out.level_side     = r_res.level_side;
    assign o_out.level_price    = r_res.level_price;
    assign o_out.level_quantity = r_res.level_quantity;
    assign o_out.level_orders   = r_res.level_orders;
    assign o_out.bid_levels     = r_res.bid_levels;
    assign o_out.ask_levels     = r_res.ask_levels;
    assign o_out.crossed        = r_res.crossed;
    assign o_out.last           = r_res.last;

    // ---------------- checks ----------------
    `PLD_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, (r_bid_cnt <= CW'(MAX_DEPTH)) && (r_ask_cnt <= CW'(MAX_DEPTH)), "level count beyond row length")
    `PLD_ASSERT_NOW(a_ovf_needs_match, i_clk, i_rst_n, w_commit, !w_sel_stat.ovf || w_sel_stat.match, "overflow flagged without a price match")
    `PLD_ASSERT_NEXT(a_ovf_sticky, i_clk, i_rst_n, w_commit && w_sel_stat.ovf, r_sticky, "overflow did not set sticky error")
    `PLD_ASSERT_NEXT(a_bid_step, i_clk, i_rst_n, 1'b1, (r_bid_cnt == $past(r_bid_cnt)) || (r_bid_cnt == $past(r_bid_cnt) + CW'(1)) || (r_bid_cnt == '0), "bid count jumped")

endmodule

`default_nettype wire

// File: sv/pld_cell.sv
// ---------------------------------------------------------------------------
// pld_cell
// One book entry: compares against the incoming level, precomputes the
// aggregated sums, and loads a sum, the new level, or its neighbor's entry.
// ---------------------------------------------------------------------------
`default_nettype none

module pld_cell (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_is_ask,
    input  logic            i_wr_sum,
    input  logic            i_wr_new,
    input  logic            i_wr_shift,
    input  pld_pkg::t_entry i_item,
    input  pld_pkg::t_entry i_prev,
    output pld_pkg::t_entry o_entry,
    output logic            o_eq,
    output logic            o_ahead,
    output logic            o_ovf
);
    import pld_pkg::*;

    t_entry           r_entry;
    logic             r_eq;
    logic             r_ahead;
    logic             r_ovf;
    logic [QTY_W-1:0] r_qsum;
    logic [ORD_W-1:0] r_osum;
    logic [QTY_W:0]   w_qsum;
    logic [ORD_W:0]   w_osum;

    assign w_qsum = {1'b0, r_entry.quantity} + {1'b0, i_item.quantity};
    assign w_osum = {1'b0, r_entry.orders} + {1'b0, i_item.orders};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_eq    <= (r_entry.price == i_item.price);
            // ahead: this entry sorts before the incoming price
            r_ahead <= i_is_ask ? ($signed(r_entry.price) < $signed(i_item.price))
                                : ($signed(r_entry.price) > $signed(i_item.price));
            r_qsum  <= w_qsum[QTY_W-1:0];
            r_osum  <= w_osum[ORD_W-1:0];
            r_ovf   <= w_qsum[QTY_W] | w_osum[ORD_W];
        end
        if (i_wr_sum) begin
            r_entry.quantity <= r_qsum;
            r_entry.orders   <= r_osum;
        end else if (i_wr_new) begin
            r_entry <= i_item;
        end else if (i_wr_shift) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;
    assign o_eq    = r_eq;
    assign o_ahead = r_ahead;
    assign o_ovf   = r_ovf;

endmodule

`default_nettype wire

// File: sv/pld_side.sv
// ---------------------------------------------------------------------------
// pld_side
// One side of the book: a row of entry cells, ordered best first, with the
// insert/shift decode that ties neighbors together.
// ---------------------------------------------------------------------------
`default_nettype none

module pld_side #(
    parameter int  MAX_DEPTH = 16,
    localparam int CW = $clog2(MAX_DEPTH + 1),
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  logic                   i_clk,
    input  pld_pkg::t_side_ctl     i_ctl,
    input  pld_pkg::t_entry        i_item,
    input  logic [CW-1:0]          i_count,
    input  logic [CW-1:0]          i_cap,
    input  logic [IW-1:0]          i_rd_idx,
    output pld_pkg::t_side_stat    o_stat,
    output pld_pkg::t_entry        o_rd,
    output logic signed [31:0]     o_head_price
);
    import pld_pkg::*;

    t_entry                 w_ent [MAX_DEPTH];
    logic [MAX_DEPTH-1:0]   w_eq;
    logic [MAX_DEPTH-1:0]   w_ahead;
    logic [MAX_DEPTH-1:0]   w_ovf;
    logic [MAX_DEPTH-1:0]   w_valid;
    logic [MAX_DEPTH-1:0]   w_eqm;
    logic [MAX_DEPTH-1:0]   w_am;
    logic [CW-1:0]          w_cap_m1;
    logic                   w_match;
    logic                   w_ovf_any;
    logic                   w_drop;
    logic                   w_ins_ok;

    assign w_eqm     = w_eq & w_valid;
    assign w_am      = w_ahead & w_valid;
    assign w_match   = |w_eqm;
    assign w_ovf_any = |(w_eqm & w_ovf);
    assign w_cap_m1  = i_cap - CW'(1);
    // the held entries are sorted, so w_am is a run of ones from the head
    assign w_drop    = w_am[w_cap_m1[IW-1:0]];
    assign w_ins_ok  = i_ctl.commit & ~w_match & ~w_drop;

    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
        logic   w_wr_new;
        logic   w_wr_shift;
        t_entry w_prev;

        assign w_valid[g] = (i_count > CW'(g));

        if (g == 0) begin : g_head
            assign w_wr_new   = w_ins_ok & ~w_am[0];
            assign w_wr_shift = 1'b0;
            assign w_prev     = i_item;
        end else begin : g_body
            assign w_wr_new   = w_ins_ok & w_am[g-1] & ~w_am[g];
            assign w_wr_shift = w_ins_ok & ~w_am[g-1];
            assign w_prev     = w_ent[g-1];
        end

        pld_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (i_ctl.load),
            .i_is_ask   (i_ctl.is_ask),
            .i_wr_sum   (i_ctl.commit & w_match & ~w_ovf_any & w_eqm[g]),
            .i_wr_new   (w_wr_new),
            .i_wr_shift (w_wr_shift),
            .i_item     (i_item),
            .i_prev     (w_prev),
            .o_entry    (w_ent[g]),
            .o_eq       (w_eq[g]),
            .o_ahead    (w_ahead[g]),
            .o_ovf      (w_ovf[g])
        );
    end

    assign o_stat.match = w_match;
    assign o_stat.ovf   = w_ovf_any;
    assign o_stat.drop  = w_drop;
    assign o_rd         = w_ent[i_rd_idx];
    assign o_head_price = w_ent[0].price;

endmodule

`default_nettype wire

// File: tb/price_level_depth_merger_test.sv
// ---------------------------------------------------------------------------
// price_level_depth_merger_test
// Self-checking bench for the bid/ask depth merger. A queue-fed driver sends
// clear, merge, finish and unused-op words with random gaps; a monitor keeps its own
// copy of both sides of the book, predicts every status, level and summary
// word, and compares each returned word field by field. The depth limit is
// rewritten over APB between phases while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module price_level_depth_merger_test;
    import pld_pkg::*;

    localparam int          DEPTH          = 16;
    localparam int          SIDE_BID       = 0;
    localparam int          SIDE_ASK       = 1;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [63:0] QTY_FULL       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] ORD_FULL       = 32'hFFFF_FFFF;
    localparam int          RANDOM_ITEMS   = 460;
    localparam int          IDLE_PCT       = 15;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_LEVEL_LIMIT, 2'b00};

    typedef struct {
        logic [1:0]         op;
        logic               side;
        logic signed [31:0] price;
        logic [63:0]        quantity;
        logic [31:0]        orders;
    } t_cmd;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    pld_in_if  level_in();
    pld_out_if word_out();

    price_level_depth_merger #(
        .MAX_DEPTH(DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (level_in),
        .o_out   (word_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    t_cmd  level_feed[$];
    t_res  depth_words_due[$];
    int    random_items;
    int    fault_count;
    int    quiet_cycles;
    bit    no_idle;
    logic  in_fire;

    // predicted book
    t_entry         book[2][DEPTH];
    int             side_cnt[2];
    bit             sticky_err;
    logic [LIMIT_W-1:0] limit_reg;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int eff_limit();
        if (limit_reg == '0)
            return 1;
        if (limit_reg > DEPTH)
            return DEPTH;
        return limit_reg;
    endfunction

    // returns 1 when the aggregate would overflow
    function automatic bit fold_level(int s, logic signed [31:0] p, logic [63:0] q,
                                      logic [31:0] o);
        int          cap;
        int          i;
        int          ins;
        logic [64:0] qsum;
        logic [32:0] osum;
        cap = eff_limit();
        for (i = 0; i < side_cnt[s]; i++) begin
            if ($signed(book[s][i].price) == p) begin
                qsum = {1'b0, book[s][i].quantity} + {1'b0, q};
                osum = {1'b0, book[s][i].orders} + {1'b0, o};
                if (qsum[64] || osum[32])
                    return 1'b1;
                book[s][i].quantity = qsum[63:0];
                book[s][i].orders   = osum[31:0];
                return 1'b0;
            end
        end
        ins = 0;
        while (ins < side_cnt[s] &&
               ((s == SIDE_ASK) ? ($signed(book[s][ins].price) < p)
                                : ($signed(book[s][ins].price) > p)))
            ins++;
        if (ins >= cap)
            return 1'b0;
        // with the limit lowered below the count the tail just falls off
        if (side_cnt[s] < cap)
            side_cnt[s]++;
        for (i = side_cnt[s] - 1; i > ins; i--)
            book[s][i] = book[s][i-1];
        book[s][ins].price    = p;
        book[s][ins].quantity = q;
        book[s][ins].orders   = o;
        return 1'b0;
    endfunction

    function automatic void book_apply(t_cmd c);
        t_res r;
        t_res lv;
        int   s;
        int   i;
        bit   crossed;
        r      = '0;
        r.last = 1'b1;
        case (c.op)
            OP_CLEAR: begin
                side_cnt   = '{0, 0};
                sticky_err = 1'b0;
                depth_words_due.push_back(r);
            end
            OP_MERGE: begin
                if (sticky_err) begin
                    r.status = STAT_OVF;
                end else if (fold_level(c.side ? SIDE_ASK : SIDE_BID, c.price,
                                        c.quantity, c.orders)) begin
                    sticky_err = 1'b1;
                    r.status   = STAT_OVF;
                end
                depth_words_due.push_back(r);
            end
            OP_FINISH: begin
                for (s = SIDE_BID; s <= SIDE_ASK; s++) begin
                    for (i = 0; i < side_cnt[s]; i++) begin
                        lv                = '0;
                        lv.kind           = KIND_LEVEL;
                        lv.level_side     = (s == SIDE_ASK);
                        lv.level_price    = book[s][i].price;
                        lv.level_quantity = book[s][i].quantity;
                        lv.level_orders   = book[s][i].orders;
                        depth_words_due.push_back(lv);
                    end
                end
                crossed = !sticky_err && side_cnt[SIDE_BID] != 0 && side_cnt[SIDE_ASK] != 0
                          && ($signed(book[SIDE_BID][0].price) >
                              $signed(book[SIDE_ASK][0].price));
                r.kind       = KIND_SUMMARY;
                r.status     = sticky_err ? STAT_OVF : (crossed ? STAT_CROSSED : STAT_NONE);
                r.bid_levels = side_cnt[SIDE_BID][LEVELS_W-1:0];
                r.ask_levels = side_cnt[SIDE_ASK][LEVELS_W-1:0];
                r.crossed    = crossed;
                depth_words_due.push_back(r);
            end
            default: ;  // unused op: no word back
        endcase
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fault_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // driver and output ready
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : feed_drive
        t_cmd c;
        if (!i_rst_n) begin
            level_in.valid <= 1'b0;
        end else if (!level_in.valid || in_fire) begin
            if (level_feed.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                c = level_feed.pop_front();
                level_in.op       <= c.op;
                level_in.side     <= c.side;
                level_in.price    <= c.price;
                level_in.quantity <= c.quantity;
                level_in.orders   <= c.orders;
                level_in.valid    <= 1'b1;
            end else begin
                level_in.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        word_out.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // monitor: predict on accepted commands, check returned words
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : book_watch
        t_cmd c;
        t_res want;
        in_fire <= level_in.valid && level_in.ready;
        if (i_rst_n) begin
            if (level_in.valid && level_in.ready) begin
                c.op       = level_in.op;
                c.side     = level_in.side;
                c.price    = level_in.price;
                c.quantity = level_in.quantity;
                c.orders   = level_in.orders;
                book_apply(c);
            end
            if (word_out.valid && word_out.ready) begin
                if (depth_words_due.size() == 0) begin
                    $error("result word with nothing expected, kind %0d", word_out.kind);
                    fault_count++;
                end else begin
                    want = depth_words_due.pop_front();
                    check_field("kind", want.kind, word_out.kind);
                    check_field("status", want.status, word_out.status);
                    check_field("level_side", want.level_side, word_out.level_side);
                    check_field("level_price", 64'(unsigned'(want.level_price)),
                                64'(unsigned'(word_out.level_price)));
                    check_field("level_quantity", want.level_quantity,
                                word_out.level_quantity);
                    check_field("level_orders", want.level_orders, word_out.level_orders);
                    check_field("bid_levels", want.bid_levels, word_out.bid_levels);
                    check_field("ask_levels", want.ask_levels, word_out.ask_levels);
                    check_field("crossed", want.crossed, word_out.crossed);
                    check_field("last", want.last, word_out.last);
                end
            end
            if ((level_in.valid && level_in.ready) || (word_out.valid && word_out.ready) ||
                (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_cmd make_cmd(logic [1:0] op, logic side, logic signed [31:0] price,
                                      logic [63:0] quantity, logic [31:0] orders);
        t_cmd c;
        c.op       = op;
        c.side     = side;
        c.price    = price;
        c.quantity = quantity;
        c.orders   = orders;
        return c;
    endfunction

    task automatic queue_cmd(t_cmd c);
        level_feed.push_back(c);
        if (c.op != OP_UNUSED)
            random_items++;
    endtask

    // prices cluster near a base so repeats, crossing and full sides happen
    function automatic t_cmd level_cmd(logic signed [31:0] base);
        t_cmd c;
        int   pick;
        c.op    = OP_MERGE;
        c.side  = $urandom_range(0, 1);
        c.price = base + $urandom_range(0, 24);
        pick = $urandom_range(0, 99);
        if (pick < 85)
            c.quantity = $urandom_range(1, 5000);
        else if (pick < 95)
            c.quantity = {$urandom, $urandom};
        else
            c.quantity = QTY_FULL - $urandom_range(0, 5000);
        pick = $urandom_range(0, 99);
        if (pick < 85)
            c.orders = $urandom_range(1, 50);
        else if (pick < 95)
            c.orders = $urandom;
        else
            c.orders = ORD_FULL - $urandom_range(0, 50);
        return c;
    endfunction

    function automatic t_cmd noise_cmd();
        return make_cmd($urandom_range(0, 3), $urandom_range(0, 1), $urandom,
                        {$urandom, $urandom}, $urandom);
    endfunction

    task automatic make_book_run(int merges, bit with_clear, bit with_finish);
        logic signed [31:0] base;
        int                 k;
        if ($urandom_range(0, 3) == 0)
            base = $urandom;
        else
            base = $urandom_range(0, 200) - 100;
        if (with_clear)
            queue_cmd(make_cmd(OP_CLEAR, 1'b0, '0, '0, '0));
        for (k = 0; k < merges; k++) begin
            if ($urandom_range(0, 99) < 6)
                queue_cmd(noise_cmd());
            else
                queue_cmd(level_cmd(base));
        end
        if (with_finish)
            queue_cmd(make_cmd(OP_FINISH, 1'b0, '0, '0, '0));
    endtask

    task automatic random_book_run();
        make_book_run($urandom_range(1, 30), $urandom_range(0, 9) != 0,
                      $urandom_range(0, 9) != 0);
    endtask

    // drain everything, then leave room for a finish or unused op to retire
    task automatic wait_quiet(int pause);
        while (level_feed.size() != 0 || level_in.valid || depth_words_due.size() != 0)
            @(negedge i_clk);
        repeat (pause) @(negedge i_clk);
    endtask

    task automatic set_limit(logic [LIMIT_W-1:0] value);
        wait_quiet(SETTLE_CYCLES);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= LIMIT_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        limit_reg  = value;
    endtask

    function automatic logic [LIMIT_W-1:0] random_limit();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return $urandom_range(1, DEPTH);
        if (pick == 7)
            return '0;
        return $urandom_range(DEPTH + 1, 31);
    endfunction

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        level_in.valid    = 1'b0;
        level_in.op       = OP_CLEAR;
        level_in.side     = 1'b0;
        level_in.price    = '0;
        level_in.quantity = '0;
        level_in.orders   = '0;
        word_out.ready    = 1'b0;
        in_fire           = 1'b0;
        no_idle           = 1'b0;
        fault_count       = 0;
        quiet_cycles      = 0;
        random_items      = 0;
        side_cnt          = '{0, 0};
        sticky_err        = 1'b0;
        limit_reg         = LIMIT_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty book, extreme prices and sizes, crossing, overflow
        queue_cmd(make_cmd(OP_FINISH, 1'b0, '0, '0, '0));
        queue_cmd(make_cmd(OP_MERGE, 1'b0, 32'sh7FFF_FFFF, QTY_FULL, ORD_FULL));
        queue_cmd(make_cmd(OP_MERGE, 1'b0, 32'sh8000_0000, '0, '0));
        queue_cmd(make_cmd(OP_MERGE, 1'b1, 32'sd0, 64'd1, 32'd1));
        queue_cmd(make_cmd(OP_MERGE, 1'b1, 32'sh8000_0000, 64'd5, 32'd3));
        queue_cmd(make_cmd(OP_MERGE, 1'b0, 32'sd0, 64'd7, 32'd2));
        queue_cmd(make_cmd(OP_FINISH, 1'b0, '0, '0, '0));
        queue_cmd(make_cmd(OP_MERGE, 1'b1, 32'sd0, 64'd9, 32'd9));
        queue_cmd(make_cmd(OP_MERGE, 1'b0, 32'sd0, 64'hFFFF_FFFF_FFFF_FFF9, 32'd1));
        queue_cmd(make_cmd(OP_MERGE, 1'b1, 32'sd5, 64'd1, 32'd1));  // ignored: sticky
        queue_cmd(make_cmd(OP_FINISH, 1'b0, '0, '0, '0));
        queue_cmd(make_cmd(OP_UNUSED, 1'b1, -32'sd1, QTY_FULL, ORD_FULL));
        queue_cmd(make_cmd(OP_CLEAR, 1'b1, -32'sd1, QTY_FULL, ORD_FULL));
        queue_cmd(make_cmd(OP_MERGE, 1'b0, 32'sd100, 64'd10, 32'hFFFF_FFFE));
        queue_cmd(make_cmd(OP_MERGE, 1'b0, 32'sd100, 64'd20, 32'd1));
        queue_cmd(make_cmd(OP_MERGE, 1'b0, 32'sd100, 64'd0, 32'd1));   // order count overflows
        queue_cmd(make_cmd(OP_CLEAR, 1'b0, '0, '0, '0));
        queue_cmd(make_cmd(OP_MERGE, 1'b1, 32'sd50, 64'd1, 32'd1));
        queue_cmd(make_cmd(OP_MERGE, 1'b1, 32'sd40, 64'd2, 32'd1));
        queue_cmd(make_cmd(OP_MERGE, 1'b0, 32'sd30, 64'd3, 32'd1));
        queue_cmd(make_cmd(OP_MERGE, 1'b1, 32'sd60, 64'd4, 32'd1));
        queue_cmd(make_cmd(OP_MERGE, 1'b0, 32'sd35, 64'd5, 32'd1));
        queue_cmd(make_cmd(OP_FINISH, 1'b0, '0, '0, '0));
        queue_cmd(make_cmd(OP_MERGE, 1'b0, 32'sd45, 64'd6, 32'd1));
        queue_cmd(make_cmd(OP_FINISH, 1'b0, '0, '0, '0));

        // limit extremes, including values the block clamps
        set_limit(5'd1);
        repeat (3) random_book_run();
        set_limit(5'd0);
        repeat (3) random_book_run();
        set_limit(5'd31);
        no_idle = 1'b1;
        repeat (5) random_book_run();
        set_limit(5'd17);
        no_idle = 1'b0;
        repeat (2) random_book_run();

        // fill a side, then lower the limit under the held count
        set_limit(5'd16);
        make_book_run(26, 1'b1, 1'b0);
        set_limit(5'd3);
        make_book_run(10, 1'b0, 1'b1);

        while (random_items < RANDOM_ITEMS) begin
            set_limit(random_limit());
            repeat (3) random_book_run();
        end

        wait_quiet(4 * SETTLE_CYCLES);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: price_level_depth_merger.f
+incdir+sv
sv/pld_pkg.sv
sv/pld_if.sv
sv/pld_cell.sv
sv/pld_side.sv
sv/price_level_depth_merger.sv
tb/price_level_depth_merger_test.sv
